// ===== rtl/cbd_pkg.sv =====
// Shared types for the convolutional byte deinterleaver.
`default_nettype none

package cbd_pkg;

  localparam int DATA_W = 8;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

`default_nettype wire

// ===== rtl/cbd_if.sv =====
// Stream interfaces for the deinterleaver input and output transactions.
`default_nettype none

interface cbd_in_if;
  import cbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_in;
  logic  resync;

  modport source (output valid, data_in, resync, input ready);
  modport sink (input valid, data_in, resync, output ready);
endinterface

interface cbd_out_if;
  import cbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_out;

  modport source (output valid, data_out, input ready);
  modport sink (input valid, data_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/convolutional_byte_deinterleaver.sv =====
// Convolutional byte deinterleaver with a BRANCHES-way commutator and alignment delay.
//
// Takes one byte per clock and gives one byte per clock while the output is not stalled; a
// result passes the position memory read at the accepting edge, then the branch store read,
// then the output register. Branch c delays by FIRST_DEPTH - DEPTH_STEP*c
// bytes, the last branch passes through, and every byte then passes an ALIGN_DEPTH-byte
// delay. resync zeroes the commutator before its byte. All delay lines read as zero until
// first written, so the block is ready right after reset with no clearing pass.
// Back-pressure on the output stalls the whole pipeline.
`default_nettype none

module convolutional_byte_deinterleaver #(
  parameter int BRANCHES    = 52,
  parameter int DEPTH_STEP  = 4,
  parameter int FIRST_DEPTH = 204,
  parameter int ALIGN_DEPTH = 156
) (
  input  logic      clk,
  input  logic      rst,
  cbd_in_if.sink    interleaved,
  cbd_out_if.source deinterleaved
);
  import cbd_pkg::*;

  function automatic int dlen(input int c);
    int l;
    l = FIRST_DEPTH - DEPTH_STEP * c;
    return (l > 0) ? l : 0;
  endfunction

  function automatic int dbase(input int c);
    int b;
    b = 0;
    for (int k = 0; k < c; k++) begin
      b += dlen(k);
    end
    return b;
  endfunction

  localparam int DELAY_BRANCHES = BRANCHES - 1;
  localparam int CW             = $clog2(BRANCHES);
  localparam int PW             = $clog2(FIRST_DEPTH + 1);
  localparam int STORE_DEPTH    = dbase(DELAY_BRANCHES);
  localparam int AW             = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ALW            = (ALIGN_DEPTH > 1) ? $clog2(ALIGN_DEPTH) : 1;
  localparam int SEL_N          = 2 ** CW;

  // per-branch constants
  logic [PW-1:0] len_tab  [SEL_N];
  logic [AW-1:0] base_tab [SEL_N];

  for (genvar g = 0; g < SEL_N; g++) begin : g_tab
    localparam int L = (g < DELAY_BRANCHES) ? dlen(g) : 0;
    localparam int B = (g < DELAY_BRANCHES) ? dbase(g) : 0;
    assign len_tab[g]  = PW'(L);
    assign base_tab[g] = AW'(B);
  end

  logic adv;
  logic acc;

  assign adv               = !deinterleaved.valid || deinterleaved.ready;
  assign interleaved.ready = adv;
  assign acc               = interleaved.valid && adv;

  // commutator and alignment pointer
  logic [CW-1:0]  sel;
  logic [CW-1:0]  sel_next;
  logic [CW-1:0]  c_a;
  logic [ALW-1:0] ap;
  logic [ALW-1:0] ap_next;
  logic           ap_wrap;
  logic           awrap;

  always_comb begin
    c_a      = interleaved.resync ? '0 : sel;
    sel_next = (c_a == CW'(BRANCHES - 1)) ? '0 : c_a + 1'b1;
    ap_wrap  = (ap == ALW'(ALIGN_DEPTH - 1));
    ap_next  = ap_wrap ? '0 : ap + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel   <= '0;
      ap    <= '0;
      awrap <= 1'b0;
    end else if (acc) begin
      sel <= sel_next;
      ap  <= ap_next;
      if (ap_wrap) begin
        awrap <= 1'b1;
      end
    end
  end

  // stage B: branch position lookup
  logic           vb;
  logic [CW-1:0]  cb;
  byte_t          byte_b;
  logic [ALW-1:0] ap_b;
  logic           afill_b;

  logic [PW-1:0]  pos_mem [SEL_N];
  logic [PW-1:0]  pos_rd;
  logic [SEL_N-1:0] pos_vld;
  logic [SEL_N-1:0] brw;
  logic           pos_wv;
  logic [CW-1:0]  pos_wc;
  logic [PW-1:0]  pos_wval;

  logic [PW-1:0]  len_b;
  logic           pass_b;
  logic [PW-1:0]  pos_b;
  logic [PW:0]    pos_inc;
  logic           wraps_b;
  logic [PW-1:0]  pos_nx;
  logic [AW-1:0]  addr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cb      <= c_a;
      byte_b  <= interleaved.data_in;
      ap_b    <= ap;
      afill_b <= awrap;
      pos_rd  <= pos_mem[c_a];
      if (vb && !pass_b) begin
        pos_mem[cb] <= pos_nx;
      end
    end
  end

  always_comb begin
    len_b   = len_tab[cb];
    pass_b  = (len_b == '0);
    if (pos_wv && pos_wc == cb) begin
      pos_b = pos_wval;
    end else if (pos_vld[cb]) begin
      pos_b = pos_rd;
    end else begin
      pos_b = '0;
    end
    pos_inc = {1'b0, pos_b} + 1'b1;
    wraps_b = (pos_inc >= {1'b0, len_b});
    pos_nx  = wraps_b ? '0 : pos_inc[PW-1:0];
    addr_b  = base_tab[cb] + AW'(pos_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld <= '0;
      brw     <= '0;
      pos_wv  <= 1'b0;
    end else if (adv) begin
      pos_wv <= vb && !pass_b;
      if (vb && !pass_b) begin
        pos_vld[cb] <= 1'b1;
        if (wraps_b) begin
          brw[cb] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_wc   <= cb;
      pos_wval <= pos_nx;
    end
  end

  // stage C: branch store and alignment store
  logic           vc;
  logic           pass_c;
  byte_t          byte_c;
  logic [AW-1:0]  addr_c;
  logic           filled_c;
  logic [ALW-1:0] ap_c;
  logic           afill_c;

  byte_t          store_mem [STORE_DEPTH];
  byte_t          st_rd;
  logic           st_wv;
  logic [AW-1:0]  st_wa;
  byte_t          st_wd;

  byte_t          al_mem [ALIGN_DEPTH];
  byte_t          al_rd;
  logic           al_wv;
  logic [ALW-1:0] al_wa;
  byte_t          al_wd;

  byte_t          br_c;
  byte_t          al_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc    <= 1'b0;
      st_wv <= 1'b0;
      al_wv <= 1'b0;
    end else if (adv) begin
      vc    <= vb;
      st_wv <= vc && !pass_c;
      al_wv <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass_c   <= pass_b;
      byte_c   <= byte_b;
      addr_c   <= addr_b;
      filled_c <= brw[cb];
      ap_c     <= ap_b;
      afill_c  <= afill_b;
      st_wa    <= addr_c;
      st_wd    <= byte_c;
      al_wa    <= ap_c;
      al_wd    <= br_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_rd <= store_mem[addr_b];
      if (vc && !pass_c) begin
        store_mem[addr_c] <= byte_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al_rd <= al_mem[ap_b];
      if (vc) begin
        al_mem[ap_c] <= br_c;
      end
    end
  end

  always_comb begin
    if (pass_c) begin
      br_c = byte_c;
    end else if (st_wv && st_wa == addr_c) begin
      br_c = st_wd;
    end else if (filled_c) begin
      br_c = st_rd;
    end else begin
      br_c = '0;
    end

    if (al_wv && al_wa == ap_c) begin
      al_c = al_wd;
    end else if (afill_c) begin
      al_c = al_rd;
    end else begin
      al_c = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      deinterleaved.valid <= 1'b0;
    end else if (adv) begin
      deinterleaved.valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deinterleaved.data_out <= al_c;
    end
  end

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, sel} < (CW + 1)'(BRANCHES))
    else $error("commutator beyond last branch");

  a_resync: assert property (@(posedge clk) disable iff (rst)
    acc && interleaved.resync |=> sel == CW'(1))
    else $error("resync did not restart commutator");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    vb && !pass_b |-> pos_b < len_b)
    else $error("branch position beyond branch length");

  a_ap_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ap} < (ALW + 1)'(ALIGN_DEPTH))
    else $error("alignment pointer beyond depth");

  a_last_pass: assert property (@(posedge clk) disable iff (rst)
    vb && cb == CW'(BRANCHES - 1) |-> pass_b)
    else $error("last branch must pass through");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for convolutional_byte_deinterleaver: scoreboard with a commutator/delay model.
`default_nettype none

module testbench;
  import cbd_pkg::*;

  class deinterleave_board;
    localparam int BRANCHES    = 52;
    localparam int DEPTH_STEP  = 4;
    localparam int FIRST_DEPTH = 204;
    localparam int ALIGN_DEPTH = 156;

    byte_t       lane_mem[BRANCHES-1][FIRST_DEPTH];
    int unsigned lane_ptr[BRANCHES-1];
    int unsigned lane_sel;
    byte_t       skew_mem[ALIGN_DEPTH];
    int unsigned skew_ptr;
    byte_t       expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned accepted;
    int unsigned resyncs;

    function new();
      foreach (lane_mem[c, k]) lane_mem[c][k] = '0;
      foreach (lane_ptr[c]) lane_ptr[c] = 0;
      foreach (skew_mem[k]) skew_mem[k] = '0;
      lane_sel = 0;
      skew_ptr = 0;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      resyncs  = 0;
    endfunction

    function int lane_len(int unsigned c);
      int len;
      len = FIRST_DEPTH - DEPTH_STEP * int'(c);
      return (len > 0) ? len : 0;
    endfunction

    // One accepted input transaction: advance the commutator, branch and alignment delays.
    function void note_input(byte_t din, bit sync);
      byte_t lane_out;
      int    len;
      accepted++;
      if (sync) begin
        lane_sel = 0;
        resyncs++;
      end
      expected_q.push_back(skew_mem[skew_ptr]);
      lane_out = din;
      if (lane_sel < BRANCHES - 1) begin
        len = lane_len(lane_sel);
        if (len > 0) begin
          lane_out = lane_mem[lane_sel][lane_ptr[lane_sel]];
          lane_mem[lane_sel][lane_ptr[lane_sel]] = din;
          lane_ptr[lane_sel] = (lane_ptr[lane_sel] + 1 >= len) ? 0 : lane_ptr[lane_sel] + 1;
        end
      end
      lane_sel = (lane_sel + 1 >= BRANCHES) ? 0 : lane_sel + 1;
      skew_mem[skew_ptr] = lane_out;
      skew_ptr = (skew_ptr + 1 >= ALIGN_DEPTH) ? 0 : skew_ptr + 1;
    endfunction

    function void check_output(byte_t actual);
      byte_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, expected none, actual %02h",
                 $time, actual);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (actual !== want) begin
        errors++;
        $display("%0t: data_out mismatch, expected %02h, actual %02h", $time, want, actual);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 650;
  localparam int SEGMENT      = 52;
  localparam int SETTLE       = 12;
  localparam int TIMEOUT      = 12 * 400000;

  logic clk;
  logic rst;
  bit   steady;

  deinterleave_board board;

  cbd_in_if  in_bus();
  cbd_out_if out_bus();

  convolutional_byte_deinterleaver DUT (
    .clk           (clk),
    .rst           (rst),
    .interleaved   (in_bus),
    .deinterleaved (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(byte_t din, bit sync);
    while (!steady && $urandom_range(99) < 35) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.data_in = din;
    in_bus.resync  = sync;
    do @(posedge clk); while (!in_bus.ready);
    board.note_input(din, sync);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    byte_t edge_bytes[6];
    edge_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE};
    push_byte(8'hA5, 1'b1);
    foreach (edge_bytes[k]) push_byte(edge_bytes[k], 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h55, 1'b1);
    push_byte(8'h33, 1'b1);
    for (int k = 0; k < 15; k++) push_byte(byte_t'(k * 17), k == 9);
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned mode;
    int unsigned len;
    int unsigned gap;
    bit          drained;
    sent    = 0;
    drained = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 200 && sent < 350);
      if (!drained && sent >= 420) begin
        wait_drained();
        drained = 1;
      end
      mode = $urandom_range(9);
      if (mode < 6) begin
        // well-formed segment: sync on its first byte
        for (int k = 0; k < SEGMENT; k++) push_byte(byte_t'($urandom_range(255)), k == 0);
        sent += SEGMENT;
      end else if (mode < 8) begin
        len = $urandom_range(1, 70);
        for (int k = 0; k < len; k++)
          push_byte(byte_t'($urandom_range(255)), $urandom_range(19) == 0);
        sent += len;
      end else begin
        // short syncs keep the commutator on the longest branches
        len = $urandom_range(4, 40);
        gap = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) push_byte(byte_t'($urandom_range(255)), k % gap == 0);
        sent += len;
      end
    end
    steady = 0;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = steady || ($urandom_range(99) >= 35);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_bus.valid && out_bus.ready) board.check_output(out_bus.data_out);
    end
  end

  initial begin
    board          = new();
    steady         = 0;
    rst            = 1'b1;
    in_bus.valid   = 1'b0;
    in_bus.data_in = '0;
    in_bus.resync  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d bytes (%0d with resync), compared %0d output bytes.",
             board.accepted, board.resyncs, board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
